/* hdl/sha256_hash_engine_defines.svh */
// Assertion macros used by the engine controller.
`ifndef SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA256_HASH_ENGINE_DEFINES_SVH

// Check a consequence in the same cycle.
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the next cycle.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/sha_pkg.sv */
`timescale 1ns / 1ps

package sha_pkg;

	typedef enum logic [1:0] {
		BSEL_DATA = 2'd0,
		BSEL_PAD  = 2'd1,
		BSEL_ZERO = 2'd2,
		BSEL_LEN  = 2'd3
	} byte_sel_t;

	typedef struct packed {
		logic      shift_en;
		byte_sel_t byte_sel;
		logic [2:0] len_idx;
		logic      count_en;
		logic      load_work;
		logic      round_en;
		logic [5:0] round_idx;
		logic      fold;
		logic      reinit;
		logic [2:0] word_idx;
	} dp_cmd_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [2:0] LAST_WORD = 3'd7;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

endpackage

/* hdl/sha_dp.sv */
`timescale 1ns / 1ps

module sha_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  sha_pkg::dp_cmd_t cmd,
	input  logic [7:0]       data_byte,
	output logic [31:0]      digest_word
);

	logic [511:0] blk_q;
	logic [31:0]  work_q [8];
	logic [31:0]  chain_q [8];
	logic [60:0]  msg_q;

	logic [63:0] len_bits;
	logic [7:0]  byte_in;
	logic [31:0] w0, w1, w9, w14, w_new;
	logic [31:0] s0, s1, big0, big1, ch, maj, t1, t2;
	logic [31:0] a, b, c, d, e, f, g, h;

	assign len_bits = {msg_q, 3'b000};

	always_comb begin
		case (cmd.byte_sel)
			sha_pkg::BSEL_DATA: byte_in = data_byte;
			sha_pkg::BSEL_PAD:  byte_in = sha_pkg::PAD_BYTE;
			sha_pkg::BSEL_LEN:  byte_in = len_bits[{~cmd.len_idx, 3'b000} +: 8];
			default:            byte_in = 8'h00;
		endcase
	end

	assign w0  = blk_q[511:480];
	assign w1  = blk_q[479:448];
	assign w9  = blk_q[223:192];
	assign w14 = blk_q[63:32];

	assign s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
	assign s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
	assign w_new = w0 + s0 + w9 + s1;

	assign a = work_q[0];
	assign b = work_q[1];
	assign c = work_q[2];
	assign d = work_q[3];
	assign e = work_q[4];
	assign f = work_q[5];
	assign g = work_q[6];
	assign h = work_q[7];

	assign big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
	assign ch   = (e & f) ^ (~e & g);
	assign t1   = h + big1 + ch + sha_pkg::ROUND_K[cmd.round_idx] + w0;
	assign big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
	assign maj  = (a & b) ^ (a & c) ^ (b & c);
	assign t2   = big0 + maj;

	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			blk_q <= {blk_q[503:0], byte_in};
		end else if (cmd.round_en) begin
			blk_q <= {blk_q[479:0], w_new};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_work) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (cmd.round_en) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= a;
			work_q[2] <= b;
			work_q[3] <= c;
			work_q[4] <= d + t1;
			work_q[5] <= e;
			work_q[6] <= f;
			work_q[7] <= g;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha_pkg::INIT_HASH[i];
			end
			msg_q <= '0;
		end else begin
			if (cmd.reinit) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= sha_pkg::INIT_HASH[i];
				end
				msg_q <= '0;
			end else begin
				if (cmd.fold) begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + work_q[i];
					end
				end
				if (cmd.count_en) begin
					msg_q <= msg_q + 61'd1;
				end
			end
		end
	end

	assign digest_word = chain_q[cmd.word_idx];

endmodule

/* hdl/sha_ctrl.sv */
`timescale 1ns / 1ps
`include "sha256_hash_engine_defines.svh"

module sha_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             has_byte,
	input  logic             end_of_message,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       word_index,
	output logic             last_word,
	output sha_pkg::dp_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PAD   = 6'b000010,
		S_INIT  = 6'b000100,
		S_ROUND = 6'b001000,
		S_FOLD  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t     state_q;
	logic [5:0] fill_q;
	logic [5:0] rnd_q;
	logic [2:0] idx_q;
	logic       first_q;
	logic       zero_tail_q;
	logic       final_q;
	logic       pad_q;
	logic       end_pend_q;

	logic in_acc;
	logic out_acc;

	assign in_acc   = in_valid && (state_q == S_IDLE);
	assign out_acc  = (state_q == S_OUT) && !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid  = (state_q == S_OUT);
	assign word_index = idx_q;
	assign last_word  = (idx_q == sha_pkg::LAST_WORD);

	always_comb begin
		cmd = '0;
		cmd.byte_sel  = sha_pkg::BSEL_DATA;
		cmd.len_idx   = fill_q[2:0];
		cmd.round_idx = rnd_q;
		cmd.word_idx  = idx_q;
		case (state_q)
			S_IDLE: begin
				cmd.shift_en = in_acc && has_byte;
				cmd.count_en = in_acc && has_byte;
			end
			S_PAD: begin
				cmd.shift_en = 1'b1;
				if (first_q) begin
					cmd.byte_sel = sha_pkg::BSEL_PAD;
				end else if (fill_q >= sha_pkg::LEN_POS && !zero_tail_q) begin
					cmd.byte_sel = sha_pkg::BSEL_LEN;
				end else begin
					cmd.byte_sel = sha_pkg::BSEL_ZERO;
				end
			end
			S_INIT:  cmd.load_work = 1'b1;
			S_ROUND: cmd.round_en = 1'b1;
			S_FOLD:  cmd.fold = 1'b1;
			S_OUT:   cmd.reinit = out_acc && (idx_q == sha_pkg::LAST_WORD);
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			rnd_q       <= '0;
			idx_q       <= '0;
			first_q     <= 1'b0;
			zero_tail_q <= 1'b0;
			final_q     <= 1'b0;
			pad_q       <= 1'b0;
			end_pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (has_byte) begin
							fill_q <= fill_q + 6'd1;
						end
						if (has_byte && fill_q == sha_pkg::LAST_POS) begin
							end_pend_q <= end_of_message;
							state_q    <= S_INIT;
						end else if (end_of_message) begin
							first_q <= 1'b1;
							pad_q   <= 1'b1;
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					fill_q  <= fill_q + 6'd1;
					first_q <= 1'b0;
					if (first_q && fill_q >= sha_pkg::LEN_POS) begin
						zero_tail_q <= 1'b1;
					end
					if (fill_q == sha_pkg::LAST_POS) begin
						final_q <= !first_q && !zero_tail_q;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == sha_pkg::LAST_ROUND) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					zero_tail_q <= 1'b0;
					if (pad_q) begin
						state_q <= final_q ? S_OUT : S_PAD;
					end else if (end_pend_q) begin
						end_pend_q <= 1'b0;
						first_q    <= 1'b1;
						pad_q      <= 1'b1;
						state_q    <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == sha_pkg::LAST_WORD) begin
							pad_q   <= 1'b0;
							final_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SHA_ASSERT_NOW(a_out_empty_block, out_valid, fill_q == 6'd0 && !first_q, "digest shown with block bytes pending")
	`SHA_ASSERT_NEXT(a_round_to_fold, state_q == S_ROUND && rnd_q == sha_pkg::LAST_ROUND, state_q == S_FOLD, "rounds did not end in fold")
	`SHA_ASSERT_NEXT(a_last_word_done, out_acc && last_word, !out_valid && !pad_q, "digest did not end after last word")
	`SHA_ASSERT_NEXT(a_full_block_compress, in_acc && has_byte && fill_q == sha_pkg::LAST_POS, state_q == S_INIT, "full block not compressed")

endmodule

/* hdl/sha256_hash_engine.sv */
`timescale 1ns / 1ps
// channel | signals                                   | direction
// input   | in_valid in_stall data_byte has_byte end_of_message | item in
// output  | out_valid out_stall digest_word word_index last_word | item out
// Bytes are taken back to back while idle; a block's 64th byte starts
// load, 64 rounds of the single round unit, fold into the chaining words.
// An end item pads one byte per cycle up to the block end, then compresses
// one or two blocks and shows eight digest words, one per taken item.
// in_stall is high while a block compresses, and from an end item
// until the last digest word is taken.
// Reset (arst_n low) loads the initial hash values and clears all counts.

module sha256_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha_pkg::dp_cmd_t cmd;

	sha_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.word_index     (word_index),
		.last_word      (last_word),
		.cmd            (cmd)
	);

	sha_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.digest_word (digest_word)
	);

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASE_ITEMS = 120;
	localparam int PHASE_DIGESTS = 4;

	localparam int BOUNDARY_LENS [11] = '{54, 55, 56, 57, 62, 63, 64, 65, 119, 120, 128};

	localparam bit [31:0] START_HASH [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam bit [31:0] ROUND_CONST [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	typedef struct {
		bit [31:0] word;
		bit [2:0]  index;
		bit        last;
	} digest_word_t;

	class digest_scoreboard;
		bit [31:0]    hash_state [8];
		bit [7:0]     block_bytes [64];
		int           block_fill;
		bit [60:0]    msg_len;
		digest_word_t pending_words[$];
		int           errors;
		int           words_checked;
		int           digests_predicted;

		function new();
			errors = 0;
			words_checked = 0;
			digests_predicted = 0;
			clear_message();
		endfunction

		function void clear_message();
			int i;
			for (i = 0; i < 8; i++)
				hash_state[i] = START_HASH[i];
			block_fill = 0;
			msg_len = '0;
		endfunction

		function bit [31:0] rotr(bit [31:0] v, int n);
			return (v >> n) | (v << (32 - n));
		endfunction

		function void mix_block();
			bit [31:0] w [64];
			bit [31:0] v [8];
			bit [31:0] s0;
			bit [31:0] s1;
			bit [31:0] t1;
			bit [31:0] t2;
			int i;
			for (i = 0; i < 16; i++)
				w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
					block_bytes[4*i+3]};
			for (i = 16; i < 64; i++) begin
				s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = w[i-16] + s0 + w[i-7] + s1;
			end
			for (i = 0; i < 8; i++)
				v[i] = hash_state[i];
			for (i = 0; i < 64; i++) begin
				s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
				t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
				s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
				t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (i = 0; i < 8; i++)
				hash_state[i] = hash_state[i] + v[i];
		endfunction

		function void note_input(bit [7:0] data, bit has_data, bit finish);
			bit [63:0]    bit_len;
			digest_word_t dw;
			int i;
			if (has_data) begin
				block_bytes[block_fill] = data;
				block_fill++;
				msg_len++;
				if (block_fill == 64) begin
					mix_block();
					block_fill = 0;
				end
			end
			if (!finish)
				return;
			bit_len = {msg_len, 3'b000};
			block_bytes[block_fill] = 8'h80;
			block_fill++;
			if (block_fill > 56) begin
				for (i = block_fill; i < 64; i++)
					block_bytes[i] = 8'h00;
				mix_block();
				block_fill = 0;
			end
			for (i = block_fill; i < 56; i++)
				block_bytes[i] = 8'h00;
			for (i = 0; i < 8; i++)
				block_bytes[56+i] = bit_len[63-8*i -: 8];
			mix_block();
			for (i = 0; i < 8; i++) begin
				dw.word = hash_state[i];
				dw.index = i[2:0];
				dw.last = (i == 7);
				pending_words.push_back(dw);
			end
			digests_predicted++;
			clear_message();
		endfunction

		function void check_result(logic [31:0] word, logic [2:0] index, logic last);
			digest_word_t dw;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected digest word %h index %0d last %b", $time, word, index,
					last);
				errors++;
				return;
			end
			dw = pending_words.pop_front();
			words_checked++;
			if (word !== dw.word) begin
				$display("%0t: digest_word expected %h actual %h", $time, dw.word, word);
				errors++;
			end
			if (index !== dw.index) begin
				$display("%0t: word_index expected %0d actual %0d", $time, dw.index, index);
				errors++;
			end
			if (last !== dw.last) begin
				$display("%0t: last_word expected %b actual %b", $time, dw.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        has_byte = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	digest_scoreboard sb = new();
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int items_sent = 0;
	int noise_sent = 0;
	int messages_sent = 0;
	int cycle_count = 0;

	sha256_hash_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.has_byte(has_byte),
		.end_of_message(end_of_message),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(digest_word, word_index, last_word);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	task automatic send_item(input bit [7:0] data, input bit has_data, input bit finish);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= data;
		has_byte <= has_data;
		end_of_message <= finish;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(data, has_data, finish);
		if (has_data || finish)
			items_sent++;
		else
			noise_sent++;
		if (finish)
			messages_sent++;
	endtask

	task automatic send_message(input int len, input bit end_on_byte);
		int k;
		for (k = 0; k < len; k++) begin
			if ($urandom_range(99) < 4)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(255)), 1'b1, (k == len - 1) && end_on_byte);
		end
		if (len == 0 || !end_on_byte)
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	initial begin
		int ph;
		int len;
		int pick;
		int start_items;
		int start_msgs;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(8'hC3, 1'b0, 1'b0);
		send_item(8'h5A, 1'b0, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hA5, 1'b0, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'h7E, 1'b1, 1'b0);
		send_item(8'h3C, 1'b0, 1'b0);
		send_item(8'h81, 1'b1, 1'b1);

		for (ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 63 : 0;
			rx_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 18 : 0;
			start_items = items_sent;
			start_msgs = messages_sent;
			while (items_sent - start_items < PHASE_ITEMS ||
				messages_sent - start_msgs < PHASE_DIGESTS) begin
				pick = $urandom_range(99);
				if (pick < 55)
					len = $urandom_range(12);
				else if (pick < 75)
					len = $urandom_range(40, 13);
				else if (pick < 95)
					len = BOUNDARY_LENS[$urandom_range(10)];
				else
					len = $urandom_range(200, 129);
				send_message(len, 1'($urandom_range(1)));
			end
		end
		in_valid <= 1'b0;

		while (sb.pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d messages in %0d data/end items plus %0d idle items.",
			messages_sent, items_sent, noise_sent);
		$display("Checked %0d digest words under three sender/receiver idle mixes.",
			sb.words_checked);
		if (sb.errors == 0 && sb.pending_words.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
